// ===== src/bfc_pkg.sv =====
// Shared types and constants of the Blowfish-style block cipher unit.
package bfc_pkg;

   localparam int ROUNDS    = 16;
   localparam int NKEYS     = ROUNDS + 2;
   localparam int BOX_SIZE  = 256;
   localparam int BOX_COUNT = 4;
   localparam int BOX_WORDS = BOX_SIZE * BOX_COUNT;
   // Last even table word written during key expansion.
   localparam logic [10:0] WP_LAST = 11'(NKEYS + BOX_WORDS - 2);
   localparam logic [10:0] WP_BOX0 = 11'(NKEYS);

   // Operation codes of the func field.
   localparam logic [1:0] FUNC_ENC    = 2'd0;
   localparam logic [1:0] FUNC_DEC    = 2'd1;
   localparam logic [1:0] FUNC_LOAD   = 2'd2;
   localparam logic [1:0] FUNC_EXPAND = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_req;
      logic        zero_lr;
      logic        key_load;
      logic        round_a;
      logic        round_b;
      logic        final_step;
      logic        backward;
      logic [3:0]  rnd;
      logic        clr_we;
      logic [7:0]  clr_addr;
      logic        wr_en;
      logic        wr_sel_r;
      logic [10:0] wr_addr;
      logic        res_load;
      logic        res_zero;
   } bfc_cmd_type;

endpackage

// ===== src/bfc_datapath.sv =====
// Datapath: round keys, substitution box memories, block halves and result register.
module bfc_datapath
   import bfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  bfc_cmd_type cmd,
   input  logic [31:0] req_left_in,
   input  logic [31:0] req_right_in,
   input  logic [4:0]  req_key_index,
   input  logic [31:0] req_key_word,
   output logic [31:0] rsp_left_out,
   output logic [31:0] rsp_right_out
);

   logic [31:0] rk_ff [NKEYS];
   logic [31:0] box_mem [BOX_COUNT][BOX_SIZE];
   logic [31:0] rd_ff [BOX_COUNT];
   logic [31:0] l_ff, r_ff;
   logic [31:0] res_l_ff, res_r_ff;

   logic [4:0]  k_idx;
   logic [31:0] x_word;
   logic [31:0] f_word;
   logic [31:0] fin_l_key, fin_r_key;
   logic [10:0] box_off;
   logic [31:0] wr_data;
   logic        wr_box;

   // Round key for this round, taken forward or in reverse.
   assign k_idx  = cmd.backward ? 5'(NKEYS - 1) - 5'(cmd.rnd) : 5'(cmd.rnd);
   assign x_word = l_ff ^ rk_ff[k_idx];

   // Round function over the box read data.
   assign f_word = ((rd_ff[0] + rd_ff[1]) ^ rd_ff[2]) + rd_ff[3];

   assign fin_l_key = cmd.backward ? rk_ff[0] : rk_ff[NKEYS - 1];
   assign fin_r_key = cmd.backward ? rk_ff[1] : rk_ff[NKEYS - 2];

   // Expansion write target: round keys first, then the boxes in order.
   assign box_off = cmd.wr_addr - WP_BOX0;
   assign wr_box  = cmd.wr_en && (cmd.wr_addr >= WP_BOX0);
   assign wr_data = cmd.wr_sel_r ? r_ff : l_ff;

   // Round key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NKEYS; i++) begin
            rk_ff[i] <= 32'(i);
         end
      end else if (cmd.key_load) begin
         if (req_key_index < 5'(NKEYS)) begin
            rk_ff[req_key_index] <= {27'b0, req_key_index} ^ req_key_word;
         end
      end else if (cmd.wr_en && (cmd.wr_addr < WP_BOX0)) begin
         rk_ff[cmd.wr_addr[4:0]] <= wr_data;
      end
   end

   // Box memories: one write and one registered read port each.
   always_ff @(posedge clock) begin
      for (int b = 0; b < BOX_COUNT; b++) begin
         if (cmd.clr_we) begin
            box_mem[b][cmd.clr_addr] <= {24'b0, cmd.clr_addr};
         end else if (wr_box && (box_off[9:8] == 2'(b))) begin
            box_mem[b][box_off[7:0]] <= wr_data;
         end
         rd_ff[b] <= box_mem[b][x_word[8 * (3 - b) +: 8]];
      end
   end

   // Block halves.
   always_ff @(posedge clock) begin
      priority if (cmd.load_req) begin
         l_ff <= req_left_in;
         r_ff <= req_right_in;
      end else if (cmd.zero_lr) begin
         l_ff <= '0;
         r_ff <= '0;
      end else if (cmd.round_a) begin
         l_ff <= x_word;
      end else if (cmd.round_b) begin
         l_ff <= r_ff ^ f_word;
         r_ff <= l_ff;
      end else if (cmd.final_step) begin
         l_ff <= r_ff ^ fin_l_key;
         r_ff <= l_ff ^ fin_r_key;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_l_ff <= cmd.res_zero ? 32'b0 : l_ff;
         res_r_ff <= cmd.res_zero ? 32'b0 : r_ff;
      end
   end

   assign rsp_left_out  = res_l_ff;
   assign rsp_right_out = res_r_ff;

endmodule

// ===== src/bfc_controller.sv =====
// Controller: sequences rounds, box clearing and key expansion writes.
module bfc_controller
   import bfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_func,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bfc_cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_RA    = 8'b0000_0100,
      ST_RB    = 8'b0000_1000,
      ST_FIN   = 8'b0001_0000,
      ST_WR0   = 8'b0010_0000,
      ST_WR1   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  rnd_ff, rnd_in;
   logic [7:0]  clr_ff, clr_in;
   logic [10:0] wp_ff, wp_in;
   logic        exp_ff, exp_in;
   logic        back_ff, back_in;
   logic        keyop_ff, keyop_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept;
   logic        slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      clr_in   = clr_ff;
      wp_in    = wp_ff;
      exp_in   = exp_ff;
      back_in  = back_ff;
      keyop_in = keyop_ff;
      cmd      = '0;
      cmd.rnd      = rnd_ff;
      cmd.backward = back_ff;
      cmd.clr_addr = clr_ff;
      cmd.wr_addr  = wp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            clr_in     = clr_ff + 8'd1;
            if (clr_ff == 8'hff) begin
               rnd_in   = '0;
               state_in = exp_ff ? ST_RA : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rnd_in = '0;
               unique case (req_func)
                  FUNC_ENC, FUNC_DEC: begin
                     cmd.load_req = 1'b1;
                     back_in      = req_func[0];
                     keyop_in     = 1'b0;
                     state_in     = ST_RA;
                  end
                  FUNC_LOAD: begin
                     cmd.key_load = 1'b1;
                     keyop_in     = 1'b1;
                     state_in     = ST_DONE;
                  end
                  default: begin
                     cmd.zero_lr = 1'b1;
                     back_in     = 1'b0;
                     keyop_in    = 1'b1;
                     exp_in      = 1'b1;
                     wp_in       = '0;
                     clr_in      = '0;
                     state_in    = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_RA: begin
            cmd.round_a = 1'b1;
            state_in    = ST_RB;
         end
         ST_RB: begin
            cmd.round_b = 1'b1;
            rnd_in      = rnd_ff + 4'd1;
            state_in    = (rnd_ff == 4'(ROUNDS - 1)) ? ST_FIN : ST_RA;
         end
         ST_FIN: begin
            cmd.final_step = 1'b1;
            state_in       = exp_ff ? ST_WR0 : ST_DONE;
         end
         ST_WR0: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_WR1;
         end
         ST_WR1: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel_r = 1'b1;
            cmd.wr_addr  = wp_ff + 11'd1;
            wp_in        = wp_ff + 11'd2;
            rnd_in       = '0;
            if (wp_ff == WP_LAST) begin
               exp_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_RA;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.res_load = 1'b1;
               cmd.res_zero = keyop_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Result valid: set on load, cleared when the receiver takes the result (rsp_stall low).
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers; reset starts the box clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rnd_ff       <= '0;
         clr_ff       <= '0;
         wp_ff        <= '0;
         exp_ff       <= 1'b0;
         back_ff      <= 1'b0;
         keyop_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         exp_ff       <= exp_in;
         back_ff      <= back_in;
         keyop_ff     <= keyop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/blowfish_block_cipher_unit.sv =====
// Encrypt or decrypt: each round runs through ST_RA and ST_RB, split by the registered
// read of the box memories, then whitening in ST_FIN and hand-off in ST_DONE.
// A new transaction is taken only once the unit is idle again. A key word load goes
// straight to ST_DONE. Key expansion: a box clearing pass, then 521 chained encryptions.
// After reset a clearing pass sets every box entry to its index; req_stall stays high
// until it ends. A finished result waits in an output register.
module blowfish_block_cipher_unit
   import bfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_left_in,
   input  logic [31:0] req_right_in,
   input  logic [4:0]  req_key_index,
   input  logic [31:0] req_key_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_left_out,
   output logic [31:0] rsp_right_out
);

   bfc_cmd_type cmd;

   // Sequencer.
   bfc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Tables and block halves.
   bfc_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .req_key_index (req_key_index),
      .req_key_word  (req_key_word),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule

// ===== src/bfc_checker.sv =====
// Port-level checker for the cipher unit and its bind statement.
module bfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_left_out,
   input logic [31:0] rsp_right_out
);

   // The clearing pass holds off input right after reset.
   a_reset_busy: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input taken during clearing pass");

   // An accepted transaction makes the unit busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("unit not busy after accepting a transaction");

   // A new result only appears while the unit was working on it.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out)))
      else $error("stalled result changed");

endmodule

bind blowfish_block_cipher_unit bfc_checker u_bfc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out)
);
